FILE: sv/lpcc_pkg.sv
// Shared types, constants and tables for the line position and color classifier.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package lpcc_pkg;

  localparam int DIV_LAT   = 32;  // one quotient bit per stage
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;

  localparam int PD_W       = 10;
  localparam int CNT_W      = 16;
  localparam int STR_FRAC   = 12;
  localparam int STR_W      = STR_FRAC + 1;
  localparam int RATIO_FRAC = 8;
  localparam int RATIO_W    = 31;
  localparam int RATIO_SCALE = 100 << RATIO_FRAC;
  localparam int SCALE_W    = 15;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 48;
  localparam int DEC_W      = 50;
  localparam int N_CLASS    = 4;
  localparam int N_CH       = 3;

  localparam int WSUM_W  = 16;
  localparam int TOTAL_W = 15;
  localparam int POS_W   = 15;
  localparam int QPOS_W  = 14;

  localparam int CAL_PD_W = 20;
  localparam int CAL_C_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  // Classifier result leaves its module this many stages after its inputs.
  localparam int CLS_LAT   = DIV_LAT + 3;
  localparam int COLOR_DLY = DIV_LAT - 2;
  localparam int PIPE_LAT  = 2 * DIV_LAT + 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_IL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_IR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_CW = 3'd4;

  localparam logic [CAL_PD_W-1:0] RST_CAL_OL = 20'd359463;
  localparam logic [CAL_PD_W-1:0] RST_CAL_IL = 20'd345126;
  localparam logic [CAL_PD_W-1:0] RST_CAL_IR = 20'd351269;
  localparam logic [CAL_PD_W-1:0] RST_CAL_OR = 20'd320547;
  localparam logic [CAL_C_W-1:0]  RST_CAL_CW = 32'd655363200;

  typedef enum logic [2:0] {
    CLASS_BLACK = 3'd0,
    CLASS_RED   = 3'd1,
    CLASS_GREEN = 3'd2,
    CLASS_BLUE  = 3'd3,
    CLASS_WHITE = 3'd4
  } color_e;

  typedef enum logic [1:0] {
    STR_DIV  = 2'd0,
    STR_ONE  = 2'd1,
    STR_ZERO = 2'd2
  } str_mode_e;

  // Special-case flags of the color channel that ride along the divider.
  typedef struct packed {
    logic white;
    logic zero;
  } cls_flags_t;

  // Classifier weights scaled by 10000, rows black, red, green, blue.
  localparam logic signed [COEF_W-1:0] COEFF [N_CLASS][N_CH] = '{
    '{ 16'sd1129,    16'sd743,    -16'sd1    },
    '{ 16'sd29690,  -16'sd9396,    16'sd4897 },
    '{-16'sd13199,   16'sd17235,  -16'sd9846 },
    '{-16'sd19934,   16'sd5089,    16'sd15674 }
  };
  localparam logic signed [DEC_W-1:0] ICPT [N_CLASS] = '{
    -50'sd77428, -50'sd936174, -50'sd38712, -50'sd57054
  };

endpackage

FILE: sv/lpcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Depends on lpcc_pkg for its widths and depth.
`timescale 1ns / 1ps

module lpcc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [lpcc_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [lpcc_pkg::DIV_DEN_W-1:0] den_i,
  output logic [lpcc_pkg::DIV_NUM_W-1:0] quo_o
);

  localparam int NW = lpcc_pkg::DIV_NUM_W;
  localparam int DW = lpcc_pkg::DIV_DEN_W;
  localparam int L  = lpcc_pkg::DIV_LAT;

  logic [NW-1:0] num_q [L];
  logic [NW-1:0] num_d [L];
  logic [NW-1:0] quo_q [L];
  logic [NW-1:0] quo_d [L];
  logic [DW-1:0] rem_q [L];
  logic [DW-1:0] rem_d [L];
  logic [DW-1:0] den_q [L];
  logic [DW-1:0] den_d [L];

  always_comb begin
    logic [NW-1:0] s_num, s_quo;
    logic [DW-1:0] s_rem, s_den;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < L; k++) begin
      if (k == 0) begin
        s_num = num_i;
        s_quo = '0;
        s_rem = '0;
        s_den = den_i;
      end else begin
        s_num = num_q[k-1];
        s_quo = quo_q[k-1];
        s_rem = rem_q[k-1];
        s_den = den_q[k-1];
      end
      trial    = {s_rem, s_num[NW-1]};
      ge       = trial >= {1'b0, s_den};
      rem_d[k] = ge ? DW'(trial - {1'b0, s_den}) : trial[DW-1:0];
      quo_d[k] = {s_quo[NW-2:0], ge};
      num_d[k] = {s_num[NW-2:0], 1'b0};
      den_d[k] = s_den;
    end
  end

  // Datapath only; the caller tracks which stages hold live transactions.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
      den_q <= den_d;
    end
  end

  assign quo_o = quo_q[L-1];

  // rst_ni is unused by the datapath; keep it referenced for the assertion.
  // Stages that have not yet seen real data hold unknown values and are skipped.
  property p_rem_below_den;
    @(posedge clk_i) disable iff (!rst_ni)
      den_q[L-1] != '0 && !$isunknown({rem_q[L-1], den_q[L-1]}) |->
        rem_q[L-1] < den_q[L-1];
  endproperty
  a_rem_below_den: assert property (p_rem_below_den)
    else $error("divider remainder not below divisor");

  a_quo_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> quo_q[1][NW-1:1] === $past(quo_q[0][NW-2:0]))
    else $error("divider quotient did not shift between stages");

  a_den_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> den_q[L-1] === $past(den_q[L-2]))
    else $error("divider divisor lost between stages");

endmodule

FILE: sv/lpcc_lane.sv
// One strength lane: maps a sample between black and white levels to 1.0..0.0.
// Depends on lpcc_pkg and lpcc_div.
`timescale 1ns / 1ps

module lpcc_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [lpcc_pkg::CNT_W-1:0] val_i,
  input  logic [lpcc_pkg::CNT_W-1:0] blk_i,
  input  logic [lpcc_pkg::CNT_W-1:0] wht_i,
  output logic [lpcc_pkg::STR_W-1:0] str_o
);

  localparam int L = lpcc_pkg::DIV_LAT;

  lpcc_pkg::str_mode_e mode_d;
  lpcc_pkg::str_mode_e mode_q [L];
  logic [lpcc_pkg::DIV_NUM_W-1:0] num;
  logic [lpcc_pkg::DIV_DEN_W-1:0] den;
  logic [lpcc_pkg::DIV_NUM_W-1:0] quo;

  always_comb begin
    if (val_i < blk_i) begin
      mode_d = lpcc_pkg::STR_ONE;
    end else if (val_i > wht_i) begin
      mode_d = lpcc_pkg::STR_ZERO;
    end else if (wht_i == blk_i) begin
      mode_d = lpcc_pkg::STR_ONE;
    end else begin
      mode_d = lpcc_pkg::STR_DIV;
    end
  end

  assign num = lpcc_pkg::DIV_NUM_W'(wht_i - val_i) << lpcc_pkg::STR_FRAC;
  assign den = lpcc_pkg::DIV_DEN_W'(wht_i - blk_i);

  lpcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .num_i  (num),
    .den_i  (den),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q[0] <= mode_d;
      for (int k = 1; k < L; k++) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  always_comb begin
    case (mode_q[L-1])
      lpcc_pkg::STR_ONE:  str_o = lpcc_pkg::STR_W'(1 << lpcc_pkg::STR_FRAC);
      lpcc_pkg::STR_ZERO: str_o = '0;
      default:            str_o = quo[lpcc_pkg::STR_W-1:0];
    endcase
  end

endmodule

FILE: sv/lpcc_cls.sv
// Color classifier: three ratio dividers, a product stage, a sum stage and an argmax.
// Depends on lpcc_pkg and lpcc_div.
`timescale 1ns / 1ps

module lpcc_cls (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [lpcc_pkg::CNT_W-1:0] red_i,
  input  logic [lpcc_pkg::CNT_W-1:0] green_i,
  input  logic [lpcc_pkg::CNT_W-1:0] blue_i,
  input  logic [lpcc_pkg::CNT_W-1:0] white_i,
  input  logic [lpcc_pkg::CNT_W-1:0] thresh_i,
  output lpcc_pkg::color_e           color_o
);

  localparam int L  = lpcc_pkg::DIV_LAT;
  localparam int NC = lpcc_pkg::N_CLASS;
  localparam int NH = lpcc_pkg::N_CH;

  logic [lpcc_pkg::CNT_W-1:0]     cnt   [NH];
  logic [lpcc_pkg::DIV_NUM_W-1:0] quo   [NH];
  lpcc_pkg::cls_flags_t           flg_d;
  lpcc_pkg::cls_flags_t           flg_q [L];
  lpcc_pkg::cls_flags_t           flg_p_q, flg_s_q;

  logic signed [lpcc_pkg::PROD_W-1:0] prod_d [NC][NH];
  logic signed [lpcc_pkg::PROD_W-1:0] prod_q [NC][NH];
  logic signed [lpcc_pkg::DEC_W-1:0]  dec_d  [NC];
  logic signed [lpcc_pkg::DEC_W-1:0]  dec_q  [NC];
  logic [1:0]                         best_idx;
  lpcc_pkg::color_e                   color_d, color_q;

  assign cnt[0] = red_i;
  assign cnt[1] = green_i;
  assign cnt[2] = blue_i;

  assign flg_d.white = white_i > thresh_i;
  assign flg_d.zero  = white_i == '0;

  for (genvar c = 0; c < NH; c++) begin : g_ratio
    logic [lpcc_pkg::DIV_NUM_W-1:0] num;
    assign num = lpcc_pkg::DIV_NUM_W'(cnt[c]) *
                 lpcc_pkg::DIV_NUM_W'(lpcc_pkg::RATIO_SCALE);
    lpcc_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .num_i  (num),
      .den_i  (white_i),
      .quo_o  (quo[c])
    );
  end

  always_comb begin
    logic signed [lpcc_pkg::DIV_NUM_W-1:0] ratio;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NH; j++) begin
        ratio = $signed({1'b0, quo[j][lpcc_pkg::RATIO_W-1:0]});
        prod_d[i][j] = lpcc_pkg::PROD_W'(lpcc_pkg::COEFF[i][j]) *
                       lpcc_pkg::PROD_W'(ratio);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      dec_d[i] = lpcc_pkg::DEC_W'(prod_q[i][0]) + lpcc_pkg::DEC_W'(prod_q[i][1])
               + lpcc_pkg::DEC_W'(prod_q[i][2])
               + (lpcc_pkg::ICPT[i] <<< lpcc_pkg::RATIO_FRAC);
    end
  end

  // Largest decision value wins; a tie keeps the lower class. The white and zero flags override it.
  always_comb begin
    logic signed [lpcc_pkg::DEC_W-1:0] best;
    best     = dec_q[0];
    best_idx = 2'd0;
    for (int i = 1; i < NC; i++) begin
      if (dec_q[i] > best) begin
        best     = dec_q[i];
        best_idx = 2'(i);
      end
    end
    if (flg_s_q.white) begin
      color_d = lpcc_pkg::CLASS_WHITE;
    end else if (flg_s_q.zero) begin
      color_d = lpcc_pkg::CLASS_BLACK;
    end else begin
      // Classifier rows are in class order, so the row index is the class code.
      color_d = lpcc_pkg::color_e'(3'(best_idx));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0] <= flg_d;
      for (int k = 1; k < L; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      prod_q  <= prod_d;
      flg_p_q <= flg_q[L-1];
      dec_q   <= dec_d;
      flg_s_q <= flg_p_q;
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

FILE: sv/line_position_and_color_classifier_core.sv
// Top level of the line position and color classifier: config registers, lanes, merge.
// Depends on lpcc_pkg, lpcc_lane, lpcc_cls and lpcc_div.
// A transaction passes the input register, the strength lanes, the merge register, the
// position divider and the output register in that order, with the color delayed to match.
// Throughput: one transaction per cycle; the rate is set by the bit-per-stage dividers,
// which are fully pipelined, so a new item enters whenever the output stage can move.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the default calibration.
`timescale 1ns / 1ps

module line_position_and_color_classifier_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Fields from bit 0: pd_outer_left[9:0], pd_inner_left[19:10], pd_inner_right[29:20],
  // pd_outer_right[39:30], red count[55:40], green count[71:56], blue count[87:72],
  // white count[103:88].
  input  logic [lpcc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: line_position[14:0], line_width[29:15], line_found[30],
  // color_class[33:31], zero fill [39:34].
  output logic [lpcc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [lpcc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lpcc_pkg::CAL_C_W-1:0]         cfg_wdata_i
);

  localparam int L    = lpcc_pkg::DIV_LAT;
  localparam int PL   = lpcc_pkg::PIPE_LAT;
  localparam int CD   = lpcc_pkg::COLOR_DLY;
  localparam int PDW  = lpcc_pkg::PD_W;
  localparam int CW   = lpcc_pkg::CNT_W;
  localparam int SW   = lpcc_pkg::STR_W;
  localparam int TW   = lpcc_pkg::TOTAL_W;

  // Calibration registers. The user must change them only while the pipeline is empty; the block does not enforce it.
  logic [lpcc_pkg::CAL_PD_W-1:0] cal_pd_q [4];
  logic [lpcc_pkg::CAL_C_W-1:0]  cal_cw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_pd_q[0] <= lpcc_pkg::RST_CAL_OL;
      cal_pd_q[1] <= lpcc_pkg::RST_CAL_IL;
      cal_pd_q[2] <= lpcc_pkg::RST_CAL_IR;
      cal_pd_q[3] <= lpcc_pkg::RST_CAL_OR;
      cal_cw_q    <= lpcc_pkg::RST_CAL_CW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpcc_pkg::CFG_CAL_OL: cal_pd_q[0] <= cfg_wdata_i[lpcc_pkg::CAL_PD_W-1:0];
        lpcc_pkg::CFG_CAL_IL: cal_pd_q[1] <= cfg_wdata_i[lpcc_pkg::CAL_PD_W-1:0];
        lpcc_pkg::CFG_CAL_IR: cal_pd_q[2] <= cfg_wdata_i[lpcc_pkg::CAL_PD_W-1:0];
        lpcc_pkg::CFG_CAL_OR: cal_pd_q[3] <= cfg_wdata_i[lpcc_pkg::CAL_PD_W-1:0];
        lpcc_pkg::CFG_CAL_CW: cal_cw_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves as one; it stalls only when the output register is
  // full and the sink is not taking it.
  logic          en;
  logic [PL-1:0] vld_q;

  assign en            = !vld_q[PL-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PL-2:0], s_axis_tvalid};
    end
  end

  // Input register stage.
  logic [lpcc_pkg::IN_TDATA_W-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= s_axis_tdata;
    end
  end

  logic [CW-1:0] red, green, blue, white, cblk, cwht;
  assign red   = in_q[4*PDW +: CW];
  assign green = in_q[4*PDW + CW +: CW];
  assign blue  = in_q[4*PDW + 2*CW +: CW];
  assign white = in_q[4*PDW + 3*CW +: CW];
  assign cblk  = cal_cw_q[CW-1:0];
  assign cwht  = cal_cw_q[2*CW-1:CW];

  // Five strength lanes: four photodiodes and the white channel of the color sensor.
  logic [SW-1:0] str [5];

  for (genvar p = 0; p < 4; p++) begin : g_pd
    lpcc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .val_i  (CW'(in_q[p*PDW +: PDW])),
      .blk_i  (CW'(cal_pd_q[p][PDW-1:0])),
      .wht_i  (CW'(cal_pd_q[p][2*PDW-1:PDW])),
      .str_o  (str[p])
    );
  end

  lpcc_lane u_lane_w (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .val_i  (white),
    .blk_i  (cblk),
    .wht_i  (cwht),
    .str_o  (str[4])
  );

  lpcc_pkg::color_e color_c;

  lpcc_cls u_cls (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .red_i    (red),
    .green_i  (green),
    .blue_i   (blue),
    .white_i  (white),
    .thresh_i (cwht),
    .color_o  (color_c)
  );

  // The white-class decision is cheap, so it travels beside the lanes to decide
  // whether the white channel joins the total.
  logic is_white_q [L];

  always_ff @(posedge clk_i) begin
    if (en) begin
      is_white_q[0] <= white > cwht;
      for (int k = 1; k < L; k++) begin
        is_white_q[k] <= is_white_q[k-1];
      end
    end
  end

  // Merge stage: weighted sum with weights -2, -1, +1, +2 and the total strength.
  logic signed [lpcc_pkg::WSUM_W-1:0] wsum;
  logic [TW-1:0]                      total_d;
  logic [TW-1:0]                      wmag_d;
  logic                               neg_q, neg_d [L];
  logic [TW-1:0]                      wmag_q, total_q;
  logic [TW-1:0]                      total_dq [L];
  logic                               neg_dq [L];

  always_comb begin
    wsum = - (lpcc_pkg::WSUM_W'(str[0]) <<< 1) - lpcc_pkg::WSUM_W'(str[1])
           + lpcc_pkg::WSUM_W'(str[2]) + (lpcc_pkg::WSUM_W'(str[3]) <<< 1);
    total_d = TW'(str[0]) + TW'(str[1]) + TW'(str[2]) + TW'(str[3])
            + (is_white_q[L-1] ? TW'(0) : TW'(str[4]));
    wmag_d  = wsum[lpcc_pkg::WSUM_W-1] ? TW'(-wsum) : TW'(wsum);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q   <= wsum[lpcc_pkg::WSUM_W-1];
      wmag_q  <= wmag_d;
      total_q <= total_d;
    end
  end

  // Position divider works on magnitudes; the sign is reapplied at the end, which
  // gives truncation toward zero.
  logic [lpcc_pkg::DIV_NUM_W-1:0] pos_quo;

  lpcc_div u_pos_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (lpcc_pkg::DIV_NUM_W'(wmag_q) << lpcc_pkg::STR_FRAC),
    .den_i  (lpcc_pkg::DIV_DEN_W'(total_q)),
    .quo_o  (pos_quo)
  );

  assign neg_d[0] = neg_q;
  for (genvar k = 1; k < L; k++) begin : g_neg
    assign neg_d[k] = neg_dq[k-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < L; k++) begin
        neg_dq[k] <= neg_d[k];
      end
      total_dq[0] <= total_q;
      for (int k = 1; k < L; k++) begin
        total_dq[k] <= total_dq[k-1];
      end
    end
  end

  // Color from the classifier lines up with the position divider output.
  lpcc_pkg::color_e color_dq [CD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      color_dq[0] <= color_c;
      for (int k = 1; k < CD; k++) begin
        color_dq[k] <= color_dq[k-1];
      end
    end
  end

  // Output register.
  logic                         found;
  logic [lpcc_pkg::QPOS_W-1:0]  qmag;
  logic [lpcc_pkg::POS_W-1:0]   pos_d;
  logic [lpcc_pkg::OUT_TDATA_W-1:0] out_d, out_q;

  always_comb begin
    found = total_dq[L-1] != '0;
    qmag  = pos_quo[lpcc_pkg::QPOS_W-1:0];
    if (!found) begin
      pos_d = '0;
    end else if (neg_dq[L-1]) begin
      pos_d = lpcc_pkg::POS_W'(-lpcc_pkg::POS_W'(qmag));
    end else begin
      pos_d = lpcc_pkg::POS_W'(qmag);
    end
    out_d = {6'b0, color_dq[CD-1], found, total_dq[L-1], pos_d};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

  // A result without a line carries zero position and zero width.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[30] |-> m_axis_tdata[29:0] == '0)
    else $error("line not found but position or width nonzero");

  // Total strength never exceeds five full-scale lanes.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[29:15] <= 15'd20480)
    else $error("line width out of range");

  // Position stays within -2.0 .. +2.0.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'sd8192 &&
                       $signed(m_axis_tdata[14:0]) >= -15'sd8192))
    else $error("line position out of range");

  // A held result blocks the input and freezes the whole pipeline for that cycle.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready ##1 $stable(vld_q))
    else $error("pipeline moved while output was stalled");

endmodule
